FILE: design/opp_pkg.sv
package opp_pkg;

	typedef enum logic [1:0] {
		OP_BEGIN  = 2'd0,
		OP_BYTE   = 2'd1,
		OP_FINISH = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STS_OK     = 3'd0,
		STS_BAD    = 3'd1,
		STS_BIG    = 3'd2,
		STS_PEND   = 3'd3,
		STS_NOREAD = 3'd4,
		STS_EMPTY  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_RATE   = 3'd0,
		REG_SERIAL = 3'd1,
		REG_PRESKIP = 3'd2,
		REG_FIRSTPG = 3'd3,
		REG_PPP    = 3'd4
	} cfg_idx_t;

	localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
	localparam logic [15:0] GRANULE_RATE = 16'd48000;
	localparam logic [7:0]  LACE_FULL    = 8'd255;
	localparam logic [7:0]  EOS_TYPE     = 8'h04;
	localparam int          HDR_BYTES    = 27;
	localparam logic [17:0] RATE_RST     = 18'd48000;
	localparam logic [31:0] FIRSTPG_RST  = 32'd2;
	localparam logic [7:0]  PPP_RST      = 8'd10;

	typedef struct packed {
		op_t         operation;
		logic [11:0] packet_length;
		logic [15:0] sample_count;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_of_page;
		logic       page_ready;
		logic       stream_end;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		in_item_t    item;
		logic [4:0]  full_laces;
		logic [7:0]  lace_rem;
		logic        len_zero;
		logic        fs_zero;
	} cmd_t;

	function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {b, 24'd0};
		for (int k = 0; k < 8; k++) begin
			c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

FILE: design/opp_ifs.sv
interface opp_in_if import opp_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface opp_out_if import opp_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: design/ogg_page_packer_unit.sv
// channel   role     payload
// in_ch     sink     operation, packet_length, sample_count, data_byte
// out_ch    source   status, out_byte, byte_valid, last_of_page, page_ready, stream_end
// cfg       write    cfg_we, cfg_index, cfg_data
//
// one result per transaction; items are worked one at a time by the back engine
// begin writes its lacing entries, then adds to the granule position (32-step divide)
// page close walks header, segment table and payload, crc walked one byte per cycle
// a two-entry queue lets the front take items while the back is busy
// the back holds in its emit state while the result register is not taken
// arst_n clears all control state; stores need no clearing
module ogg_page_packer_unit import opp_pkg::*; #(
	parameter int MAX_SEGMENTS = 255,
	parameter int MAX_PAYLOAD  = 3072
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	opp_in_if.sink      in_ch,
	opp_out_if.source   out_ch
);

	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	opp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	opp_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .out_ch(out_ch)
	);

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.last_of_page |-> !out_ch.data.page_ready)
		else $error("page still ready after its last byte");

	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.stream_end |->
			out_ch.data.last_of_page && out_ch.data.byte_valid)
		else $error("stream end outside last page byte");

	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.byte_valid |-> out_ch.data.status == STS_OK)
		else $error("page byte with error status");

endmodule

FILE: design/opp_front.sv
module opp_front import opp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	opp_in_if.sink in_ch,
	output logic   cmd_valid,
	output cmd_t   cmd,
	input  logic   cmd_pop
);

	cmd_t        fifo_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	cmd_t        cls;
	logic [20:0] prod;
	logic [4:0]  q0;
	logic [11:0] r0;
	logic        push, pop;

	// len / 255 by reciprocal with one correction
	always_comb begin
		prod = 21'(in_ch.data.packet_length) * 21'd257;
		q0   = prod[20:16];
		r0   = in_ch.data.packet_length - 12'(q0 * 8'd255);
		cls.item = in_ch.data;
		if (r0 >= 12'd255) begin
			cls.full_laces = q0 + 5'd1;
			cls.lace_rem   = 8'(r0 - 12'd255);
		end else begin
			cls.full_laces = q0;
			cls.lace_rem   = r0[7:0];
		end
		cls.len_zero = (in_ch.data.packet_length == 12'd0);
		cls.fs_zero  = (in_ch.data.sample_count == 16'd0);
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign cmd_valid   = (cnt_q != 2'd0);
	assign cmd         = fifo_q[rp_q];
	assign push        = in_ch.valid && in_ch.ready;
	assign pop         = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: design/opp_back.sv
module opp_back import opp_pkg::*; #(
	parameter int MAX_SEGMENTS = 255,
	parameter int MAX_PAYLOAD  = 3072
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	opp_out_if.source   out_ch
);

	localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
	localparam int PAY_W = $clog2(MAX_PAYLOAD + 1);
	localparam int LA_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int PA_W  = $clog2(MAX_PAYLOAD);
	localparam int IDX_W = $clog2(HDR_BYTES + MAX_SEGMENTS + MAX_PAYLOAD + 1);
	localparam int CMP_W = ((PAY_W > 12) ? PAY_W : 12) + 1;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_LACE = 7'b0000010,
		S_DIV  = 7'b0000100,
		S_WALK = 7'b0001000,
		S_RDA  = 7'b0010000,
		S_RDB  = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	state_t state_q;

	logic [17:0] rate_q;
	logic [31:0] serial_q;
	logic [15:0] preskip_q;
	logic [31:0] firstpg_q;
	logic [7:0]  ppp_q;

	logic [SEG_W-1:0] seg_q;
	logic [PAY_W-1:0] pay_q;
	logic [7:0]       pip_q;
	logic             any_q;
	logic [63:0]      gran_q;
	logic [31:0]      pnum_q;
	logic [11:0]      left_q;
	logic [31:0]      csum_q;
	logic [IDX_W-1:0] rdix_q;
	logic             pend_q;
	logic             end_q;

	cmd_t             cur_q;
	logic [4:0]       lcnt_q;
	logic [31:0]      num_q;
	logic [17:0]      drem_q;
	logic [31:0]      quo_q;
	logic [4:0]       dcnt_q;
	logic [IDX_W-1:0] ptr_q;
	logic [IDX_W-1:0] idx_s1;
	logic             v_s1;
	logic [31:0]      crc_q;

	status_t    rs_status_q;
	logic [7:0] rs_byte_q;
	logic       rs_valid_q, rs_last_q, rs_send_q;

	out_item_t out_q;
	logic      out_valid_q;

	logic [7:0] lac_mem [MAX_SEGMENTS];
	logic [7:0] pay_mem [MAX_PAYLOAD];
	logic [7:0] lac_rd_q, pay_rd_q;
	logic             lac_we, pay_we;
	logic [LA_W-1:0]  lac_wa, lac_ra;
	logic [7:0]       lac_wd;
	logic [PA_W-1:0]  pay_wa, pay_ra;
	logic [IDX_W-1:0] off_r, poff_r, off_b, size;
	logic [4:0]       h;
	logic [7:0]       hb, pb;

	logic [CMP_W-1:0] need, len_w, seg_w, pay_w;
	logic [18:0]      dt;
	logic             dbit;
	logic [17:0]      dnext;
	logic             idle_cfg;

	assign size = IDX_W'(HDR_BYTES) + IDX_W'(seg_q) + IDX_W'(pay_q);

	// memory read addresses follow the walk pointer
	assign off_r  = ptr_q - IDX_W'(HDR_BYTES);
	assign poff_r = off_r - IDX_W'(seg_q);
	assign lac_ra = off_r[LA_W-1:0];
	assign pay_ra = poff_r[PA_W-1:0];

	always_ff @(posedge clk) begin
		if (lac_we) lac_mem[lac_wa] <= lac_wd;
		lac_rd_q <= lac_mem[lac_ra];
	end

	always_ff @(posedge clk) begin
		if (pay_we) pay_mem[pay_wa] <= cur_q.item.data_byte;
		pay_rd_q <= pay_mem[pay_ra];
	end

	// page byte at idx_s1
	always_comb begin
		h  = idx_s1[4:0];
		hb = 8'd0;
		case (h)
			5'd0: hb = 8'h4F;
			5'd1, 5'd2: hb = 8'h67;
			5'd3: hb = 8'h53;
			5'd4: hb = 8'd0;
			5'd5: hb = end_q ? EOS_TYPE : 8'd0;
			5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13:
				hb = 8'(gran_q >> {3'(h - 5'd6), 3'b000});
			5'd14, 5'd15, 5'd16, 5'd17:
				hb = 8'(serial_q >> {2'(h - 5'd14), 3'b000});
			5'd18, 5'd19, 5'd20, 5'd21:
				hb = 8'(pnum_q >> {2'(h - 5'd18), 3'b000});
			5'd22, 5'd23, 5'd24, 5'd25:
				hb = 8'(csum_q >> {2'(h - 5'd22), 3'b000});
			5'd26: hb = 8'(seg_q);
			default: hb = 8'd0;
		endcase
		off_b = idx_s1 - IDX_W'(HDR_BYTES);
		if (idx_s1 < IDX_W'(HDR_BYTES)) pb = hb;
		else if (off_b < IDX_W'(seg_q)) pb = lac_rd_q;
		else pb = pay_rd_q;
	end

	always_comb begin
		need  = CMP_W'(cmd.full_laces) + CMP_W'(1);
		len_w = CMP_W'(cmd.item.packet_length);
		seg_w = CMP_W'(seg_q);
		pay_w = CMP_W'(pay_q);
		dt    = {drem_q, num_q[31]};
		dbit  = (dt >= 19'(rate_q));
		dnext = dbit ? 18'(dt - 19'(rate_q)) : dt[17:0];
	end

	assign cmd_pop  = (state_q == S_IDLE);
	assign lac_we   = (state_q == S_LACE);
	assign lac_wa   = LA_W'(seg_q);
	assign lac_wd   = (lcnt_q != 5'd0) ? LACE_FULL : cur_q.lace_rem;
	assign pay_wa   = PA_W'(pay_q - PAY_W'(1));
	assign idle_cfg = !any_q && !pend_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// byte write happens in the cycle after decode, from cur_q
	logic pay_wr_q;
	assign pay_we = pay_wr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rate_q      <= RATE_RST;
			serial_q    <= 32'd0;
			preskip_q   <= 16'd0;
			firstpg_q   <= FIRSTPG_RST;
			ppp_q       <= PPP_RST;
			seg_q       <= '0;
			pay_q       <= '0;
			pip_q       <= 8'd0;
			any_q       <= 1'b0;
			gran_q      <= 64'd0;
			pnum_q      <= FIRSTPG_RST;
			left_q      <= 12'd0;
			csum_q      <= 32'd0;
			rdix_q      <= '0;
			pend_q      <= 1'b0;
			end_q       <= 1'b0;
			cur_q       <= '0;
			lcnt_q      <= 5'd0;
			num_q       <= 32'd0;
			drem_q      <= 18'd0;
			quo_q       <= 32'd0;
			dcnt_q      <= 5'd0;
			ptr_q       <= '0;
			idx_s1      <= '0;
			v_s1        <= 1'b0;
			crc_q       <= 32'd0;
			rs_status_q <= STS_OK;
			rs_byte_q   <= 8'd0;
			rs_valid_q  <= 1'b0;
			rs_last_q   <= 1'b0;
			rs_send_q   <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			pay_wr_q    <= 1'b0;
		end else begin
			pay_wr_q <= 1'b0;
			if (out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cur_q       <= cmd;
						rs_status_q <= STS_OK;
						rs_byte_q   <= 8'd0;
						rs_valid_q  <= 1'b0;
						rs_last_q   <= 1'b0;
						rs_send_q   <= 1'b0;
						state_q     <= S_EMIT;
						case (cmd.item.operation)
							OP_BEGIN: begin
								if (pend_q) begin
									rs_status_q <= STS_PEND;
								end else if (left_q != 12'd0 || cmd.len_zero || cmd.fs_zero ||
										rate_q == 18'd0) begin
									rs_status_q <= STS_BAD;
								end else if (need > CMP_W'(MAX_SEGMENTS) ||
										len_w > CMP_W'(MAX_PAYLOAD)) begin
									rs_status_q <= STS_BIG;
								end else if (seg_q != '0 && (pip_q >= ppp_q ||
										seg_w + need > CMP_W'(MAX_SEGMENTS) ||
										pay_w + len_w > CMP_W'(MAX_PAYLOAD))) begin
									rs_status_q <= STS_PEND;
									csum_q  <= 32'd0;
									ptr_q   <= '0;
									v_s1    <= 1'b0;
									crc_q   <= 32'd0;
									state_q <= S_WALK;
								end else begin
									lcnt_q  <= cmd.full_laces;
									state_q <= S_LACE;
								end
							end
							OP_BYTE: begin
								if (left_q == 12'd0 || pay_q >= PAY_W'(MAX_PAYLOAD)) begin
									rs_status_q <= STS_BAD;
								end else begin
									pay_wr_q <= 1'b1;
									pay_q    <= pay_q + PAY_W'(1);
									left_q   <= left_q - 12'd1;
								end
							end
							OP_FINISH: begin
								if (pend_q) rs_status_q <= STS_PEND;
								else if (left_q != 12'd0) rs_status_q <= STS_BAD;
								else if (!any_q) rs_status_q <= STS_EMPTY;
								else begin
									end_q   <= 1'b1;
									csum_q  <= 32'd0;
									ptr_q   <= '0;
									v_s1    <= 1'b0;
									crc_q   <= 32'd0;
									state_q <= S_WALK;
								end
							end
							OP_READ: begin
								if (!pend_q) rs_status_q <= STS_NOREAD;
								else begin
									ptr_q   <= rdix_q;
									state_q <= S_RDA;
								end
							end
							default: rs_status_q <= STS_BAD;
						endcase
					end
				end
				S_LACE: begin
					seg_q <= seg_q + SEG_W'(1);
					if (lcnt_q == 5'd0) begin
						num_q   <= 32'(cur_q.item.sample_count) * 32'(GRANULE_RATE);
						drem_q  <= 18'd0;
						quo_q   <= 32'd0;
						dcnt_q  <= 5'd0;
						state_q <= S_DIV;
					end else begin
						lcnt_q <= lcnt_q - 5'd1;
					end
				end
				S_DIV: begin
					drem_q <= dnext;
					num_q  <= num_q << 1;
					quo_q  <= {quo_q[30:0], dbit};
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd31) begin
						gran_q  <= gran_q + {32'd0, quo_q[30:0], dbit};
						pip_q   <= pip_q + 8'd1;
						any_q   <= 1'b1;
						left_q  <= cur_q.item.packet_length;
						state_q <= S_EMIT;
					end
				end
				S_WALK: begin
					if (ptr_q != size) begin
						ptr_q  <= ptr_q + IDX_W'(1);
						idx_s1 <= ptr_q;
						v_s1   <= 1'b1;
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1) crc_q <= crc_step(crc_q, pb);
					if (ptr_q == size && !v_s1) begin
						csum_q  <= crc_q;
						pend_q  <= 1'b1;
						rdix_q  <= '0;
						state_q <= S_EMIT;
					end
				end
				S_RDA: begin
					idx_s1  <= ptr_q;
					state_q <= S_RDB;
				end
				S_RDB: begin
					rs_byte_q  <= pb;
					rs_valid_q <= 1'b1;
					state_q    <= S_EMIT;
					if (idx_s1 + IDX_W'(1) == size) begin
						rs_last_q <= 1'b1;
						seg_q     <= '0;
						pay_q     <= '0;
						pip_q     <= 8'd0;
						pend_q    <= 1'b0;
						rdix_q    <= '0;
						pnum_q    <= pnum_q + 32'd1;
						if (end_q) begin
							rs_send_q <= 1'b1;
							end_q     <= 1'b0;
							any_q     <= 1'b0;
							gran_q    <= 64'(preskip_q);
							pnum_q    <= firstpg_q;
						end
					end else begin
						rdix_q <= rdix_q + IDX_W'(1);
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_q.status       <= rs_status_q;
						out_q.out_byte     <= rs_byte_q;
						out_q.byte_valid   <= rs_valid_q;
						out_q.last_of_page <= rs_last_q;
						out_q.page_ready   <= pend_q;
						out_q.stream_end   <= rs_send_q;
						out_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cfg_we) begin
				case (cfg_index)
					REG_RATE:   rate_q   <= cfg_data[17:0];
					REG_SERIAL: serial_q <= cfg_data;
					REG_PRESKIP: begin
						preskip_q <= cfg_data[15:0];
						if (idle_cfg) gran_q <= {48'd0, cfg_data[15:0]};
					end
					REG_FIRSTPG: begin
						firstpg_q <= cfg_data;
						if (idle_cfg) pnum_q <= cfg_data;
					end
					REG_PPP:    ppp_q <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

endmodule
